### rtl/dfpe_pkg.sv
package dfpe_pkg;

    localparam int unsigned THROTTLE_W  = 16;
    localparam int unsigned CLAMP_W     = 11;
    localparam int unsigned FRAME_W     = 16;
    localparam int unsigned TICKS_W     = 9;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned SYM_CNT_W   = 5;
    localparam int unsigned DEF_QUEUE_DEPTH = 2;

    localparam logic [SYM_CNT_W-1:0] LAST_SYMBOL = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIDIRECTIONAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_MAX  = 2'd3;

    localparam logic [MODE_W-1:0]  RST_SPEED_MODE   = 2'd2;
    localparam logic [CLAMP_W-1:0] RST_THROTTLE_MIN = 11'd48;
    localparam logic [CLAMP_W-1:0] RST_THROTTLE_MAX = 11'd2047;

    typedef enum logic [MODE_W-1:0] {
        t_dshot150  = 2'd0,
        t_dshot300  = 2'd1,
        t_dshot600  = 2'd2,
        t_dshot1200 = 2'd3
    } t_speed_mode;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [MODE_W-1:0]  mode;
        logic               inv;
    } t_frame_item;

    function automatic logic [TICKS_W-1:0] bit_ticks(input logic [MODE_W-1:0] mode);
        logic [TICKS_W-1:0] v;
        case (t_speed_mode'(mode))
            t_dshot150:  v = 9'd64;
            t_dshot300:  v = 9'd32;
            t_dshot600:  v = 9'd16;
            t_dshot1200: v = 9'd8;
            default:     v = 9'd16;
        endcase
        return v;
    endfunction

    function automatic logic [TICKS_W-1:0] high_ticks(input logic [MODE_W-1:0] mode,
                                                      input logic bit_val);
        logic [TICKS_W-1:0] v;
        case (t_speed_mode'(mode))
            t_dshot150:  v = bit_val ? 9'd48 : 9'd24;
            t_dshot300:  v = bit_val ? 9'd24 : 9'd12;
            t_dshot600:  v = bit_val ? 9'd12 : 9'd6;
            t_dshot1200: v = bit_val ? 9'd6  : 9'd3;
            default:     v = bit_val ? 9'd12 : 9'd6;
        endcase
        return v;
    endfunction

    function automatic logic [TICKS_W-1:0] pause_ticks(input logic [MODE_W-1:0] mode);
        logic [TICKS_W-1:0] v;
        case (t_speed_mode'(mode))
            t_dshot150:  v = 9'd256;
            t_dshot300:  v = 9'd128;
            t_dshot600:  v = 9'd64;
            t_dshot1200: v = 9'd32;
            default:     v = 9'd64;
        endcase
        return v;
    endfunction

endpackage

### rtl/dfpe_front.sv
module dfpe_front
    import dfpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [THROTTLE_W-1:0] i_throttle,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_frame_item           o_item
);

    logic [MODE_W-1:0]  r_speed_mode;
    logic               r_bidir;
    logic [CLAMP_W-1:0] r_thr_min;
    logic [CLAMP_W-1:0] r_thr_max;

    logic [CLAMP_W-1:0] raised;
    logic [CLAMP_W-1:0] clamped;
    logic [11:0]        word12;
    logic [3:0]         csum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_mode <= RST_SPEED_MODE;
            r_bidir      <= 1'b0;
            r_thr_min    <= RST_THROTTLE_MIN;
            r_thr_max    <= RST_THROTTLE_MAX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SPEED_MODE:    r_speed_mode <= i_cfg_data[MODE_W-1:0];
                REG_BIDIRECTIONAL: r_bidir      <= i_cfg_data[0];
                REG_THROTTLE_MIN:  r_thr_min    <= i_cfg_data[CLAMP_W-1:0];
                REG_THROTTLE_MAX:  r_thr_max    <= i_cfg_data[CLAMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (i_throttle < {{(THROTTLE_W-CLAMP_W){1'b0}}, r_thr_min})
            raised = r_thr_min;
        else if (i_throttle > {{(THROTTLE_W-CLAMP_W){1'b0}}, r_thr_max})
            raised = r_thr_max;
        else
            raised = i_throttle[CLAMP_W-1:0];
        clamped = (raised > r_thr_max) ? r_thr_max : raised;
        word12  = {clamped, 1'b0};
        csum    = word12[11:8] ^ word12[7:4] ^ word12[3:0];
        if (r_bidir)
            csum = ~csum;
    end

    assign busy          = i_q_full;
    assign o_push        = start && !i_q_full;
    assign o_item.frame  = {word12, csum};
    assign o_item.mode   = r_speed_mode;
    assign o_item.inv    = r_bidir;

endmodule

### rtl/dfpe_queue.sv
module dfpe_queue
    import dfpe_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_item i_item,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_frame_item o_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_frame_item      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            if (i_pop)
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            if (i_push && !i_pop)
                r_count <= r_count + 1'b1;
            else if (!i_push && i_pop)
                r_count <= r_count - 1'b1;
        end
    end

endmodule

### rtl/dfpe_back.sv
module dfpe_back
    import dfpe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_frame_item        i_item,
    output logic               o_pop,
    output logic               o_strobe,
    output logic               o_first_level,
    output logic [TICKS_W-1:0] o_first_ticks,
    output logic               o_second_level,
    output logic [TICKS_W-1:0] o_second_ticks,
    output logic [FRAME_W-1:0] o_frame_word,
    output logic               o_last
);

    logic                 r_act;
    logic [SYM_CNT_W-1:0] r_cnt;
    t_frame_item          r_item;

    logic                 r_strobe;
    logic                 r_first_level;
    logic [TICKS_W-1:0]   r_first_ticks;
    logic                 r_second_level;
    logic [TICKS_W-1:0]   r_second_ticks;
    logic [FRAME_W-1:0]   r_frame_word;
    logic                 r_last;

    logic                 at_pause;
    logic                 cur_bit;
    logic [TICKS_W-1:0]   hi;

    assign at_pause = (r_cnt == LAST_SYMBOL);
    assign o_pop    = !i_q_empty && (!r_act || at_pause);
    assign cur_bit  = r_item.frame[~r_cnt[3:0]];
    assign hi       = high_ticks(r_item.mode, cur_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_act;
            if (o_pop) begin
                r_act <= 1'b1;
                r_cnt <= '0;
            end else if (r_act) begin
                if (at_pause)
                    r_act <= 1'b0;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_item <= i_item;
        r_frame_word <= r_item.frame;
        if (at_pause) begin
            r_first_level  <= r_item.inv;
            r_first_ticks  <= pause_ticks(r_item.mode);
            r_second_level <= r_item.inv;
            r_second_ticks <= '0;
            r_last         <= 1'b1;
        end else begin
            r_first_level  <= !r_item.inv;
            r_first_ticks  <= hi;
            r_second_level <= r_item.inv;
            r_second_ticks <= bit_ticks(r_item.mode) - hi;
            r_last         <= 1'b0;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_first_level  = r_first_level;
    assign o_first_ticks  = r_first_ticks;
    assign o_second_level = r_second_level;
    assign o_second_ticks = r_second_ticks;
    assign o_frame_word   = r_frame_word;
    assign o_last         = r_last;

endmodule

### rtl/dshot_frame_pulse_encoder.sv
// An item taken from the queue is loaded into r_item, then its symbols are registered onto the outputs, one a cycle.
// Items follow back to back: the symbol emitter gives one symbol a cycle and takes the next item at the pause symbol.
// The queue between clamp/checksum and emitter lets start be taken while a frame is sent.
// Reset (synchronous, active low) empties the queue and restores the register defaults.
// The receiver cannot stall: each symbol is valid for one cycle while o_strobe is high.
module dshot_frame_pulse_encoder
    import dfpe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [THROTTLE_W-1:0] i_throttle,
    output logic                  o_strobe,
    output logic                  o_first_level,
    output logic [TICKS_W-1:0]    o_first_ticks,
    output logic                  o_second_level,
    output logic [TICKS_W-1:0]    o_second_ticks,
    output logic [FRAME_W-1:0]    o_frame_word,
    output logic                  o_last
);

    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    t_frame_item front_item;
    t_frame_item head_item;

    dfpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_throttle  (i_throttle),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (front_item)
    );

    dfpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (head_item)
    );

    dfpe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_item         (head_item),
        .o_pop          (pop),
        .o_strobe       (o_strobe),
        .o_first_level  (o_first_level),
        .o_first_ticks  (o_first_ticks),
        .o_second_level (o_second_level),
        .o_second_ticks (o_second_ticks),
        .o_frame_word   (o_frame_word),
        .o_last         (o_last)
    );

endmodule

### sim/dshot_symbol_checker.sv
`timescale 1ns / 1ps
module dshot_symbol_checker
    import dfpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [THROTTLE_W-1:0] i_throttle,
    input  logic                  i_strobe,
    input  logic                  i_first_level,
    input  logic [TICKS_W-1:0]    i_first_ticks,
    input  logic                  i_second_level,
    input  logic [TICKS_W-1:0]    i_second_ticks,
    input  logic [FRAME_W-1:0]    i_frame_word,
    input  logic                  i_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic               first_level;
        logic [TICKS_W-1:0] first_ticks;
        logic               second_level;
        logic [TICKS_W-1:0] second_ticks;
        logic [FRAME_W-1:0] frame_word;
        logic               last;
    } t_symbol;

    t_symbol            expected_symbols[$];
    t_speed_mode        speed_mode = t_speed_mode'(RST_SPEED_MODE);
    logic               bidir      = 1'b0;
    logic [CLAMP_W-1:0] thr_min    = RST_THROTTLE_MIN;
    logic [CLAMP_W-1:0] thr_max    = RST_THROTTLE_MAX;
    int                 fails      = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void queue_frame_symbols(input logic [THROTTLE_W-1:0] throttle);
        logic [THROTTLE_W-1:0] clamped;
        logic [11:0]           word12;
        logic [3:0]            csum;
        logic [FRAME_W-1:0]    frame;
        logic [TICKS_W-1:0]    period;
        logic [TICKS_W-1:0]    zero_hi;
        logic [TICKS_W-1:0]    one_hi;
        logic [TICKS_W-1:0]    hi;
        t_symbol               sym;
        case (speed_mode)
            t_dshot150: begin
                period = 9'd64; zero_hi = 9'd24; one_hi = 9'd48;
            end
            t_dshot300: begin
                period = 9'd32; zero_hi = 9'd12; one_hi = 9'd24;
            end
            t_dshot600: begin
                period = 9'd16; zero_hi = 9'd6; one_hi = 9'd12;
            end
            t_dshot1200: begin
                period = 9'd8; zero_hi = 9'd3; one_hi = 9'd6;
            end
            default: begin
                period = 9'd16; zero_hi = 9'd6; one_hi = 9'd12;
            end
        endcase
        clamped = throttle;
        if (clamped < THROTTLE_W'(thr_min)) clamped = THROTTLE_W'(thr_min);
        if (clamped > THROTTLE_W'(thr_max)) clamped = THROTTLE_W'(thr_max);
        word12 = {clamped[10:0], 1'b0};
        csum   = word12[3:0] ^ word12[7:4] ^ word12[11:8];
        if (bidir) csum = ~csum;
        frame = {word12, csum};
        for (int k = 0; k < 16; k++) begin
            hi = frame[15-k] ? one_hi : zero_hi;
            sym.first_level  = ~bidir;
            sym.first_ticks  = hi;
            sym.second_level = bidir;
            sym.second_ticks = period - hi;
            sym.frame_word   = frame;
            sym.last         = 1'b0;
            expected_symbols.push_back(sym);
        end
        sym.first_level  = bidir;
        sym.first_ticks  = period << 2;
        sym.second_level = bidir;
        sym.second_ticks = '0;
        sym.frame_word   = frame;
        sym.last         = 1'b1;
        expected_symbols.push_back(sym);
    endfunction

    function automatic void check_field(input string name, input logic [FRAME_W-1:0] want,
                                        input logic [FRAME_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_symbol got;
        t_symbol want;
        if (!i_rst_n) begin
            expected_symbols.delete();
            speed_mode = t_speed_mode'(RST_SPEED_MODE);
            bidir      = 1'b0;
            thr_min    = RST_THROTTLE_MIN;
            thr_max    = RST_THROTTLE_MAX;
        end else begin
            if (i_strobe) begin
                got = {i_first_level, i_first_ticks, i_second_level, i_second_ticks,
                       i_frame_word, i_last};
                if (expected_symbols.size() == 0) begin
                    $display("%0t: unexpected symbol, expected none, actual %h", $time, got);
                    fails++;
                end else begin
                    want = expected_symbols.pop_front();
                    check_field("first_level", FRAME_W'(want.first_level),
                                FRAME_W'(got.first_level));
                    check_field("first_ticks", FRAME_W'(want.first_ticks),
                                FRAME_W'(got.first_ticks));
                    check_field("second_level", FRAME_W'(want.second_level),
                                FRAME_W'(got.second_level));
                    check_field("second_ticks", FRAME_W'(want.second_ticks),
                                FRAME_W'(got.second_ticks));
                    check_field("frame_word", want.frame_word, got.frame_word);
                    check_field("last", FRAME_W'(want.last), FRAME_W'(got.last));
                end
            end
            if (i_start && !i_busy) queue_frame_symbols(i_throttle);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SPEED_MODE:    speed_mode = t_speed_mode'(i_cfg_data[MODE_W-1:0]);
                    REG_BIDIRECTIONAL: bidir      = i_cfg_data[0];
                    REG_THROTTLE_MIN:  thr_min    = i_cfg_data[CLAMP_W-1:0];
                    REG_THROTTLE_MAX:  thr_max    = i_cfg_data[CLAMP_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_symbols.size();
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import dfpe_pkg::*;

    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 34;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_SPEED_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [THROTTLE_W-1:0] i_throttle  = '0;
    logic                  o_strobe;
    logic                  o_first_level;
    logic [TICKS_W-1:0]    o_first_ticks;
    logic                  o_second_level;
    logic [TICKS_W-1:0]    o_second_ticks;
    logic [FRAME_W-1:0]    o_frame_word;
    logic                  o_last;
    int                    fail_count;
    int                    pending;

    logic [CLAMP_W-1:0]    cur_min;
    logic [CLAMP_W-1:0]    cur_max;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    dshot_frame_pulse_encoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_throttle     (i_throttle),
        .o_strobe       (o_strobe),
        .o_first_level  (o_first_level),
        .o_first_ticks  (o_first_ticks),
        .o_second_level (o_second_level),
        .o_second_ticks (o_second_ticks),
        .o_frame_word   (o_frame_word),
        .o_last         (o_last)
    );

    dshot_symbol_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (start),
        .i_busy         (busy),
        .i_throttle     (i_throttle),
        .i_strobe       (o_strobe),
        .i_first_level  (o_first_level),
        .i_first_ticks  (o_first_ticks),
        .i_second_level (o_second_level),
        .i_second_ticks (o_second_ticks),
        .i_frame_word   (o_frame_word),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    task automatic send_throttle(input logic [THROTTLE_W-1:0] value, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(0, 7));
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_throttle <= value;
        do @(posedge i_clk); while (busy);
    endtask

    // hold off until every symbol has come out, then let the pipeline settle
    task automatic drain_symbols();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] mode_word,
                                input logic [CFG_DATA_W-1:0] bidir_word,
                                input logic [CLAMP_W-1:0] min_v,
                                input logic [CLAMP_W-1:0] max_v);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{REG_SPEED_MODE, REG_BIDIRECTIONAL, REG_THROTTLE_MIN, REG_THROTTLE_MAX};
        vals = '{mode_word, bidir_word, min_v, max_v};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_min = min_v;
        cur_max = max_v;
    endtask

    task automatic send_list(input logic [THROTTLE_W-1:0] values[$]);
        foreach (values[k]) send_throttle(values[k], 1'b0);
    endtask

    function automatic logic [THROTTLE_W-1:0] pick_throttle();
        logic [THROTTLE_W-1:0] v;
        int                    r;
        r = int'($urandom_range(0, 9));
        if (r <= 5) begin
            if (cur_min <= cur_max) v = THROTTLE_W'($urandom_range(cur_min, cur_max));
            else v = THROTTLE_W'($urandom_range(0, 2047));
        end else if (r <= 7) begin
            v = THROTTLE_W'($urandom_range(0, 2047));
        end else if (r == 8) begin
            v = THROTTLE_W'($urandom);
        end else begin
            case ($urandom_range(0, 3))
                0: v = THROTTLE_W'(cur_min);
                1: v = THROTTLE_W'(cur_max);
                2: v = THROTTLE_W'(cur_min) - 1'b1;
                default: v = THROTTLE_W'(cur_max) + 1'b1;
            endcase
        end
        return v;
    endfunction

    initial begin
        logic [CLAMP_W-1:0] lo;
        logic [CLAMP_W-1:0] hi;
        logic [1:0]         mode;
        logic               inv;
        bit                 burst;
        cur_min = RST_THROTTLE_MIN;
        cur_max = RST_THROTTLE_MAX;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_list('{16'd0, 16'd47, 16'd48, 16'd49, 16'd2047, 16'd2048, 16'hFFFF,
                    16'h8000, 16'h0555, 16'h02AA});
        drain_symbols();
        apply_config(CFG_DATA_W'(t_dshot150), 11'd1, 11'd0, 11'd2047);
        send_list('{16'd0, 16'd2047, 16'h0555, 16'h02AA});
        drain_symbols();
        // minimum above maximum: result pinned to the maximum
        apply_config(CFG_DATA_W'(t_dshot1200), 11'd0, 11'd2047, 11'd0);
        send_list('{16'd0, 16'd100, 16'hFFFF});
        drain_symbols();
        apply_config(CFG_DATA_W'(t_dshot300), 11'd1, 11'd1000, 11'd1000);
        send_list('{16'd999, 16'd1000, 16'd1001});
        drain_symbols();
        apply_config(CFG_DATA_W'(t_dshot600), 11'd0, 11'd0, 11'd0);
        send_list('{16'd0, 16'd5});
        drain_symbols();

        for (int phase = 0; phase < PHASES; phase++) begin
            mode  = MODE_W'($urandom_range(0, 3));
            inv   = 1'($urandom_range(0, 1));
            burst = (phase % 3 == 1);
            if (phase == 0) begin
                mode = t_dshot150; inv = 1'b0; lo = 11'd0; hi = 11'd2047;
            end else if (phase == 1) begin
                mode = t_dshot1200; inv = 1'b1; lo = 11'd2047; hi = 11'd2047;
            end else if (phase % 5 == 4) begin
                lo = CLAMP_W'($urandom_range(0, 2047));
                hi = CLAMP_W'($urandom_range(0, 2047));
            end else begin
                lo = CLAMP_W'($urandom_range(0, 1024));
                hi = CLAMP_W'($urandom_range(lo, 2047));
            end
            apply_config({9'($urandom), mode}, {10'($urandom), inv}, lo, hi);
            for (int n = 0; n < PHASE_ITEMS; n++) send_throttle(pick_throttle(), burst);
            drain_symbols();
        end

        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/dfpe_pkg.sv
rtl/dfpe_front.sv
rtl/dfpe_queue.sv
rtl/dfpe_back.sv
rtl/dshot_frame_pulse_encoder.sv
sim/dshot_symbol_checker.sv
sim/tb_top.sv
